FILE: rtl/core/i2cram_pkg.sv
// shared types and constants for the i2c register access master
`timescale 1ns / 1ps

package i2cram_pkg;

    localparam logic [6:0] DEV_ADDR_RESET = 7'h3F;

    typedef struct packed {
        logic        kind;
        logic        is_read;
        logic [15:0] sub_addr;
        logic [7:0]  write_data;
        logic        sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } res_word_t;

endpackage

FILE: rtl/core/i2cram_seq.sv
// bus sequencer: transaction state and one pin action per tick word
`timescale 1ns / 1ps

module i2cram_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  i2cram_pkg::in_word_t  in_word,
    input  logic [6:0]            dev_addr,
    output i2cram_pkg::res_word_t res_word
);
    import i2cram_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_WBIT,
        PH_ACK,
        PH_RBIT,
        PH_NACK,
        PH_STOP
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [1:0]  byte_idx_reg,  byte_idx_next;
    logic [2:0]  bit_cnt_reg,   bit_cnt_next;
    logic [1:0]  sub_step_reg,  sub_step_next;
    logic [7:0]  shift_reg,     shift_next;
    logic [15:0] addr_reg,      addr_next;
    logic [7:0]  data_reg,      data_next;
    logic        rd_mode_reg,   rd_mode_next;
    logic        err_reg,       err_next;
    logic        scl_reg,       scl_next;
    logic        sda_reg,       sda_next;
    logic        done;
    logic [7:0]  dev_byte;
    logic [7:0]  tx_byte;

    assign dev_byte = {dev_addr, 1'b0};

    always_comb
    begin
        unique case (byte_idx_reg)
            2'd0:    tx_byte = dev_byte;
            2'd1:    tx_byte = addr_reg[15:8];
            2'd2:    tx_byte = addr_reg[7:0];
            default: tx_byte = rd_mode_reg ? (dev_byte | 8'h01) : data_reg;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        bit_cnt_next  = bit_cnt_reg;
        sub_step_next = sub_step_reg;
        shift_next    = shift_reg;
        addr_next     = addr_reg;
        data_next     = data_reg;
        rd_mode_next  = rd_mode_reg;
        err_next      = err_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        done          = 1'b0;
        if (step_en)
        begin
            if (in_word.kind)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    rd_mode_next  = in_word.is_read;
                    addr_next     = in_word.sub_addr;
                    data_next     = in_word.write_data;
                    err_next      = 1'b0;
                    byte_idx_next = 2'd0;
                    bit_cnt_next  = 3'd0;
                    sub_step_next = 2'd0;
                    phase_next    = PH_START;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_START:
                    begin
                        unique case (sub_step_reg)
                            2'd0:
                            begin
                                sda_next      = 1'b1;
                                sub_step_next = 2'd1;
                            end
                            2'd1:
                            begin
                                scl_next      = 1'b1;
                                sub_step_next = 2'd2;
                            end
                            2'd2:
                            begin
                                sda_next      = 1'b0;
                                sub_step_next = 2'd3;
                            end
                            default:
                            begin
                                scl_next      = 1'b0;
                                sub_step_next = 2'd0;
                                bit_cnt_next  = 3'd0;
                                phase_next    = PH_WBIT;
                            end
                        endcase
                    end
                    PH_WBIT:
                    begin
                        if (sub_step_reg == 2'd0)
                        begin
                            sda_next      = tx_byte[3'd7 - bit_cnt_reg];
                            sub_step_next = 2'd1;
                        end
                        else if (sub_step_reg == 2'd1)
                        begin
                            scl_next      = 1'b1;
                            sub_step_next = 2'd2;
                        end
                        else
                        begin
                            scl_next      = 1'b0;
                            sub_step_next = 2'd0;
                            bit_cnt_next  = bit_cnt_reg + 3'd1;
                            if (bit_cnt_reg == 3'd7)
                                phase_next = PH_ACK;
                        end
                    end
                    PH_ACK:
                    begin
                        if (sub_step_reg == 2'd0)
                        begin
                            sda_next      = 1'b1;
                            sub_step_next = 2'd1;
                        end
                        else if (sub_step_reg == 2'd1)
                        begin
                            scl_next      = 1'b1;
                            sub_step_next = 2'd2;
                        end
                        else
                        begin
                            if (in_word.sda_in)
                                err_next = 1'b1;
                            scl_next      = 1'b0;
                            sub_step_next = 2'd0;
                            bit_cnt_next  = 3'd0;
                            // next byte, repeated start, data phase, or stop
                            if (!rd_mode_reg)
                            begin
                                if (byte_idx_reg != 2'd3)
                                begin
                                    byte_idx_next = byte_idx_reg + 2'd1;
                                    phase_next    = PH_WBIT;
                                end
                                else
                                    phase_next = PH_STOP;
                            end
                            else if (byte_idx_reg < 2'd2)
                            begin
                                byte_idx_next = byte_idx_reg + 2'd1;
                                phase_next    = PH_WBIT;
                            end
                            else if (byte_idx_reg == 2'd2)
                            begin
                                byte_idx_next = 2'd3;
                                phase_next    = PH_START;
                            end
                            else
                                phase_next = PH_RBIT;
                        end
                    end
                    PH_RBIT:
                    begin
                        if (sub_step_reg == 2'd0)
                        begin
                            sda_next      = 1'b1;
                            sub_step_next = 2'd1;
                        end
                        else if (sub_step_reg == 2'd1)
                        begin
                            scl_next      = 1'b1;
                            sub_step_next = 2'd2;
                        end
                        else
                        begin
                            shift_next    = {shift_reg[6:0], in_word.sda_in};
                            scl_next      = 1'b0;
                            sub_step_next = 2'd0;
                            bit_cnt_next  = bit_cnt_reg + 3'd1;
                            if (bit_cnt_reg == 3'd7)
                                phase_next = PH_NACK;
                        end
                    end
                    PH_NACK:
                    begin
                        if (sub_step_reg == 2'd0)
                        begin
                            sda_next      = 1'b1;
                            sub_step_next = 2'd1;
                        end
                        else if (sub_step_reg == 2'd1)
                        begin
                            scl_next      = 1'b1;
                            sub_step_next = 2'd2;
                        end
                        else
                        begin
                            scl_next      = 1'b0;
                            sub_step_next = 2'd0;
                            phase_next    = PH_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        if (sub_step_reg == 2'd0)
                        begin
                            sda_next      = 1'b0;
                            sub_step_next = 2'd1;
                        end
                        else if (sub_step_reg == 2'd1)
                        begin
                            scl_next      = 1'b1;
                            sub_step_next = 2'd2;
                        end
                        else
                        begin
                            sda_next      = 1'b1;
                            sub_step_next = 2'd0;
                            phase_next    = PH_IDLE;
                            done          = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next    = PH_IDLE;
                        sub_step_next = 2'd0;
                        bit_cnt_next  = 3'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            byte_idx_reg <= 2'd0;
            bit_cnt_reg  <= 3'd0;
            sub_step_reg <= 2'd0;
            shift_reg    <= 8'd0;
            addr_reg     <= 16'd0;
            data_reg     <= 8'd0;
            rd_mode_reg  <= 1'b0;
            err_reg      <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            bit_cnt_reg  <= bit_cnt_next;
            sub_step_reg <= sub_step_next;
            shift_reg    <= shift_next;
            addr_reg     <= addr_next;
            data_reg     <= data_next;
            rd_mode_reg  <= rd_mode_next;
            err_reg      <= err_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
        end
    end

    always_comb
    begin
        res_word.scl_level = scl_next;
        res_word.sda_level = sda_next;
        res_word.busy_res  = (phase_next != PH_IDLE);
        res_word.done_res  = done;
        res_word.read_data = shift_next;
        res_word.ack_error = err_next;
    end

endmodule

FILE: rtl/core/i2c_register_access_master.sv
// top level of the i2c register access master with input and result registers
`timescale 1ns / 1ps

// Bit-level I2C master for one-byte register access with a 16-bit subaddress.
// Every input word yields exactly one result word: a command word loads a
// read or write transaction (ignored while busy), a tick word performs one
// pin action and reports the SCL/SDA drive levels, busy, a done pulse on the
// stop, the read shift register and the sticky acknowledge error. One word
// is accepted per clock cycle while out_stall does not hold the result word;
// the accepting edge loads the input register, and the next edge that is not
// stalled loads the result register after one pass through the sequencer. The
// device address register is written through cfg_we/cfg_wdata and should only
// change while no word is in flight.

module i2c_register_access_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        is_read,
    input  logic [15:0] sub_addr,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_error
);
    import i2cram_pkg::*;

    logic [6:0] dev_reg;
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    res_word_t out_word_reg;
    res_word_t res_word;
    logic      advance;
    logic      step_en;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign step_en  = in_valid_reg && advance;

    // device address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_reg <= DEV_ADDR_RESET;
        else if (cfg_we)
            dev_reg <= cfg_wdata;
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg.kind       <= kind;
            in_word_reg.is_read    <= is_read;
            in_word_reg.sub_addr   <= sub_addr;
            in_word_reg.write_data <= write_data;
            in_word_reg.sda_in     <= sda_in;
        end
    end

    i2cram_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .in_word  (in_word_reg),
        .dev_addr (dev_reg),
        .res_word (res_word)
    );

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_word_reg <= res_word;
    end

    assign out_valid = out_valid_reg;
    assign scl_level = out_word_reg.scl_level;
    assign sda_level = out_word_reg.sda_level;
    assign busy_res  = out_word_reg.busy_res;
    assign done_res  = out_word_reg.done_res;
    assign read_data = out_word_reg.read_data;
    assign ack_error = out_word_reg.ack_error;

endmodule
